[design/ldb_pkg.sv]
package ldb_pkg;

  // Field widths
  localparam int LATW = 31;
  localparam int LONW = 32;
  localparam int SCW  = 32;
  localparam int DW   = 36;
  localparam int BW   = 25;

  // Offset magnitude in 1/1024 m, CORDIC datapath widths
  localparam int OFW  = 42;
  localparam int GRD  = 16;
  localparam int XW   = 60;
  localparam int YW   = XW + 1;
  localparam int ZW   = 28;
  localparam int A16W = 23;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CORDIC_STEPS_MAX = 32;

  // Configuration register indexes
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_EAST_SCALE  = 1'd0;
  localparam logic [CFG_IW-1:0] REG_NORTH_SCALE = 1'd1;

  localparam logic [SCW-1:0] EAST_SCALE_RST  = 32'd47811147;
  localparam logic [SCW-1:0] NORTH_SCALE_RST = 32'd47811147;

  localparam logic [63:0]     ROUND22    = 64'd2097152;
  localparam logic [31:0]     INV_GAIN   = 32'd2608131496;
  localparam logic [ZW-2:0]   DEG90_Q20  = 27'd94371840;
  localparam logic [A16W-1:0] DEG90_Q16  = 23'd5898240;
  localparam logic signed [BW-1:0] DEG180_Q16 = 25'sd11796480;

  // atan(2^-i) in 2^-20 degree
  localparam logic [ZW-2:0] ATAN_Q20 [CORDIC_STEPS_MAX] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7,
    27'd4,        27'd2,        27'd1,        27'd0,
    27'd0,        27'd0,        27'd0,        27'd0
  };

  typedef struct packed {
    logic           north_neg;
    logic           east_neg;
    logic           n_zero;
    logic           e_zero;
    logic [OFW-1:0] byp_mag;
  } ldb_side_t;

  typedef struct packed {
    logic [XW-1:0]        x;
    logic signed [YW-1:0] y;
    logic signed [ZW-1:0] z;
    ldb_side_t            side;
  } ldb_vec_t;

endpackage

[design/ldb_offset.sv]
module ldb_offset (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  logic signed [ldb_pkg::LATW-1:0] start_lat,
  input  logic signed [ldb_pkg::LONW-1:0] start_lon,
  input  logic signed [ldb_pkg::LATW-1:0] end_lat,
  input  logic signed [ldb_pkg::LONW-1:0] end_lon,
  input  logic [ldb_pkg::SCW-1:0]        east_scale,
  input  logic [ldb_pkg::SCW-1:0]        north_scale,
  output logic                           out_vld,
  output ldb_pkg::ldb_vec_t              out_vec
);
  import ldb_pkg::*;

  // stage A: differences and magnitudes
  logic [31:0]   dlat;
  logic [32:0]   dlon;
  logic [31:0]   lat_mag_nxt, lon_mag_nxt;
  logic [31:0]   lat_mag_r, lon_mag_r;
  logic          lat_neg_r, lon_neg_r;
  logic          a_vld_r;

  // stage B: scaled products
  logic [63:0]   pn_nxt, pe_nxt;
  logic [63:0]   pn_r, pe_r;
  logic          b_lat_neg_r, b_lon_neg_r;
  logic          b_vld_r;

  // stage C: rounded offsets
  logic [63:0]   rn, re;
  logic [OFW-1:0] n_nxt, e_nxt;
  ldb_side_t     side_nxt;
  logic [OFW-1:0] n_r, e_r;
  ldb_side_t     side_r;
  logic          c_vld_r;

  assign dlat = {end_lat[LATW-1], end_lat} - {start_lat[LATW-1], start_lat};
  assign dlon = {end_lon[LONW-1], end_lon} - {start_lon[LONW-1], start_lon};

  always_comb begin
    lat_mag_nxt = dlat[31] ? (~dlat + 32'd1) : dlat;
    lon_mag_nxt = dlon[32] ? 32'(~dlon + 33'd1) : dlon[31:0];
  end

  assign pn_nxt = lat_mag_r * north_scale;
  assign pe_nxt = lon_mag_r * east_scale;

  assign rn    = pn_r + ROUND22;
  assign re    = pe_r + ROUND22;
  assign n_nxt = rn[63:22];
  assign e_nxt = re[63:22];

  always_comb begin
    side_nxt.north_neg = b_lat_neg_r;
    side_nxt.east_neg  = b_lon_neg_r;
    side_nxt.n_zero    = (n_nxt == '0);
    side_nxt.e_zero    = (e_nxt == '0);
    side_nxt.byp_mag   = side_nxt.e_zero ? n_nxt : e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_mag_r   <= lat_mag_nxt;
      lon_mag_r   <= lon_mag_nxt;
      lat_neg_r   <= dlat[31];
      lon_neg_r   <= dlon[32];
      pn_r        <= pn_nxt;
      pe_r        <= pe_nxt;
      b_lat_neg_r <= lat_neg_r;
      b_lon_neg_r <= lon_neg_r;
      n_r         <= n_nxt;
      e_r         <= e_nxt;
      side_r      <= side_nxt;
    end
  end

  assign out_vld    = c_vld_r;
  assign out_vec.x  = {{(XW - OFW - GRD){1'b0}}, n_r, {GRD{1'b0}}};
  assign out_vec.y  = $signed({{(YW - OFW - GRD){1'b0}}, e_r, {GRD{1'b0}}});
  assign out_vec.z  = '0;
  assign out_vec.side = side_r;

endmodule

[design/ldb_cell.sv]
module ldb_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  ldb_pkg::ldb_vec_t in_vec,
  output logic              out_vld,
  output ldb_pkg::ldb_vec_t out_vec
);
  import ldb_pkg::*;

  localparam logic signed [ZW-1:0] TSTEP = $signed({1'b0, ATAN_Q20[STEP]});

  logic [XW-1:0]        sx;
  logic [YW-1:0]        ay;
  logic [YW-1:0]        ay_sh;
  logic signed [YW-1:0] sx_s;
  ldb_vec_t             vec_nxt;
  ldb_vec_t             vec_r;
  logic                 vld_r;

  always_comb begin
    sx    = in_vec.x >> STEP;
    sx_s  = $signed({1'b0, sx});
    ay    = in_vec.y[YW-1] ? $unsigned(-in_vec.y) : $unsigned(in_vec.y);
    ay_sh = ay >> STEP;
    vec_nxt      = in_vec;
    vec_nxt.x    = in_vec.x + ay_sh[XW-1:0];
    // rotate towards y = 0, from the old x and y
    if (!in_vec.y[YW-1]) begin
      vec_nxt.y = in_vec.y - sx_s;
      vec_nxt.z = in_vec.z + TSTEP;
    end else begin
      vec_nxt.y = in_vec.y + sx_s;
      vec_nxt.z = in_vec.z - TSTEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_vec = vec_r;

endmodule

[design/ldb_finish.sv]
module ldb_finish (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  ldb_pkg::ldb_vec_t             in_vec,
  output logic                          out_vld,
  output logic [ldb_pkg::DW-1:0]        distance,
  output logic signed [ldb_pkg::BW-1:0] bearing
);
  import ldb_pkg::*;

  // stage F1: gain correction products and first-quadrant angle
  logic [ZW-2:0]   zc;
  logic [ZW-1:0]   zr;
  logic [A16W-1:0] a16_nxt, a16_r;
  logic [59:0]     ph_nxt, ph_r;
  logic [63:0]     pl_nxt, pl_r;
  ldb_side_t       side_r;
  logic            f1_vld_r;

  // stage F2: magnitude, saturation, quadrant
  logic [60:0]     prod;
  logic [60:0]     prod_rnd;
  logic [44:0]     mag;
  logic [DW-1:0]   dist_nxt, dist_r;
  logic [A16W-1:0] a16_sel;
  logic            nn, en;
  logic [BW-1:0]   base, bear_nxt, bear_r;
  logic            f2_vld_r;

  always_comb begin
    if (in_vec.z[ZW-1]) begin
      zc = '0;
    end else if (in_vec.z[ZW-2:0] > DEG90_Q20) begin
      zc = DEG90_Q20;
    end else begin
      zc = in_vec.z[ZW-2:0];
    end
    zr      = {1'b0, zc} + ZW'(8);
    a16_nxt = zr[A16W+3:4];
  end

  assign ph_nxt = in_vec.x[XW-1:32] * INV_GAIN;
  assign pl_nxt = in_vec.x[31:0] * INV_GAIN;

  always_comb begin
    prod     = 61'(ph_r) + 61'(pl_r[63:32]);
    prod_rnd = prod + 61'(32768);
    nn       = side_r.north_neg;
    en       = side_r.east_neg;
    a16_sel  = a16_r;
    mag      = prod_rnd[60:16];
    if (side_r.e_zero) begin
      mag     = 45'(side_r.byp_mag);
      a16_sel = '0;
      en      = 1'b0;
    end else if (side_r.n_zero) begin
      mag     = 45'(side_r.byp_mag);
      a16_sel = DEG90_Q16;
      nn      = 1'b0;
    end
    dist_nxt = (mag[44:DW] != '0) ? {DW{1'b1}} : mag[DW-1:0];
    base     = nn ? ($unsigned(DEG180_Q16) - BW'(a16_sel)) : BW'(a16_sel);
    bear_nxt = en ? (~base + BW'(1)) : base;
    // both offsets round to zero: no direction
    if (side_r.e_zero && side_r.n_zero) begin
      bear_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= in_vld;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      a16_r  <= a16_nxt;
      side_r <= in_vec.side;
      dist_r <= dist_nxt;
      bear_r <= bear_nxt;
    end
  end

  assign out_vld  = f2_vld_r;
  assign distance = dist_r;
  assign bearing  = $signed(bear_r);

endmodule

[design/local_distance_bearing.sv]
// Channel  Handshake           Payload
// in       in_valid/in_stall   in_start_lat, in_start_lon, in_end_lat, in_end_lon
// out      out_valid/out_stall out_distance, out_bearing
// cfg      cfg_wr_en           cfg_index, cfg_wdata (0 east_scale, 1 north_scale)
//
// One transaction per cycle while in_stall is low. A result passes through the
// three offset stages, one cell per CORDIC step, two finishing stages and the
// output register. rst_n is synchronous and clears all valid bits and the
// scale registers to their defaults. A stalled result is held in the output
// register while the pipeline runs on; a second result goes to a skid register,
// and in_stall rises only while that skid register is full.
module local_distance_bearing #(
  parameter int CORDIC_STEPS = ldb_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ldb_pkg::LATW-1:0]  in_start_lat,
  input  logic signed [ldb_pkg::LONW-1:0]  in_start_lon,
  input  logic signed [ldb_pkg::LATW-1:0]  in_end_lat,
  input  logic signed [ldb_pkg::LONW-1:0]  in_end_lon,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ldb_pkg::DW-1:0]           out_distance,
  output logic signed [ldb_pkg::BW-1:0]    out_bearing,
  input  logic                             cfg_wr_en,
  input  logic [ldb_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [ldb_pkg::SCW-1:0]          cfg_wdata
);
  import ldb_pkg::*;

  logic [SCW-1:0] east_scale_r, north_scale_r;

  logic           adv;
  logic           chain_vld [CORDIC_STEPS+1];
  ldb_vec_t       chain_vec [CORDIC_STEPS+1];

  logic           fin_vld;
  logic [DW-1:0]  fin_dist;
  logic signed [BW-1:0] fin_bear;

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  logic [DW-1:0]  out_dist_r, skid_dist_r;
  logic signed [BW-1:0] out_bear_r, skid_bear_r;
  logic           take, push, load_out, load_skid, out_from_skid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      east_scale_r  <= EAST_SCALE_RST;
      north_scale_r <= NORTH_SCALE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_EAST_SCALE:  east_scale_r  <= cfg_wdata;
        REG_NORTH_SCALE: north_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the pipeline runs while the skid register is free
  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  ldb_offset u_offset (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_vld      (in_valid),
    .start_lat   (in_start_lat),
    .start_lon   (in_start_lon),
    .end_lat     (in_end_lat),
    .end_lon     (in_end_lon),
    .east_scale  (east_scale_r),
    .north_scale (north_scale_r),
    .out_vld     (chain_vld[0]),
    .out_vec     (chain_vec[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    ldb_cell #(
      .STEP (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (chain_vld[k]),
      .in_vec  (chain_vec[k]),
      .out_vld (chain_vld[k+1]),
      .out_vec (chain_vec[k+1])
    );
  end

  ldb_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (chain_vld[CORDIC_STEPS]),
    .in_vec   (chain_vec[CORDIC_STEPS]),
    .out_vld  (fin_vld),
    .distance (fin_dist),
    .bearing  (fin_bear)
  );

  assign take = out_valid_r && !out_stall;
  assign push = fin_vld && adv;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    out_from_skid  = 1'b0;
    if (skid_valid_r) begin
      if (take) begin
        out_from_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_skid) begin
      out_dist_r <= skid_dist_r;
      out_bear_r <= skid_bear_r;
    end else if (load_out) begin
      out_dist_r <= fin_dist;
      out_bear_r <= fin_bear;
    end
    if (load_skid) begin
      skid_dist_r <= fin_dist;
      skid_bear_r <= fin_bear;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_bearing  = out_bear_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output");

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_bear_r <= DEG180_Q16) && (out_bear_r >= -DEG180_Q16)))
    else $error("bearing outside -180 to 180 degree");
`endif

endmodule
